// ===== src/i2cmbe_pkg.sv =====
// Package for the I2C master bit engine: command codes, item widths and the
// packed result layout. No dependencies.
package i2cmbe_pkg;

  typedef logic [2:0] cmd_t;

  localparam cmd_t CMD_IDLE  = 3'd0;
  localparam cmd_t CMD_START = 3'd1;
  localparam cmd_t CMD_WRITE = 3'd2;
  localparam cmd_t CMD_READ  = 3'd3;
  localparam cmd_t CMD_STOP  = 3'd4;

  localparam int PHASE_W    = 5;
  localparam int BYTE_W     = 8;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Phase markers inside the write and read sequences
  localparam logic [PHASE_W-1:0] PH_BITS_END  = 5'd16;
  localparam logic [PHASE_W-1:0] PH_ACK_HIGH  = 5'd17;
  localparam logic [PHASE_W-1:0] PH_NACK_DRV  = 5'd17;
  localparam logic [PHASE_W-1:0] PH_NACK_HIGH = 5'd18;
  // Highest phase held between ticks: the read's final SCL low
  localparam logic [PHASE_W-1:0] PH_LAST      = 5'd19;

  // Result item, lowest bit last
  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              ack_received;
    logic              done_res;
    logic              busy_res;
    logic              sda_drive;
    logic              sda_level;
    logic              scl_level;
  } result_t;

endpackage

// ===== src/i2c_master_bit_engine.sv =====
// Top level of the I2C master bit engine: one line phase per accepted item.
// Depends on i2cmbe_pkg for command codes and the result layout.
//
//  channel | direction | tdata (low bit up)                         | tuser
//  --------+-----------+--------------------------------------------+-----------
//  in_     | slave     | write_byte[7:0], sda_in[8], zero pad       | action[2:0]
//  out_    | master    | scl, sda, drive, busy, done, ack, byte[13:6]| -
//
// One item per cycle: the phase update is a single pass of logic from the
// state registers into the state and the result register, so an item may
// enter on every clock. The result register parts the two sides; a new item
// is taken while a result waits only if that result is taken in the same cycle.
// Synchronous active-low reset: idle, lines high and driven, no result pending.
// A stall on out_tready holds the result and drops in_tready; nothing is lost.
module i2c_master_bit_engine (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [i2cmbe_pkg::IN_DATA_W-1:0]  in_tdata,  // write_byte[7:0], sda_in[8]
  input  logic [2:0]                        in_tuser,  // action[2:0]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [i2cmbe_pkg::OUT_DATA_W-1:0] out_tdata  // scl[0], sda[1], drive[2],
                                                       // busy[3], done[4], ack[5],
                                                       // read_byte[13:6]
);

  // Engine state
  i2cmbe_pkg::cmd_t                   cmd_r, cmd_nxt;
  logic [i2cmbe_pkg::PHASE_W-1:0]     phase_r, phase_nxt;
  logic [i2cmbe_pkg::BYTE_W-1:0]      shift_r, shift_nxt;
  logic [i2cmbe_pkg::BYTE_W-1:0]      hold_r, hold_nxt;
  logic                               ack_r, ack_nxt;
  logic                               scl_r, scl_nxt;
  logic                               sda_r, sda_nxt;
  logic                               drv_r, drv_nxt;

  // Result register
  i2cmbe_pkg::result_t                res_r, res_nxt;
  logic                               out_valid_r;

  logic                               in_accept;
  logic [2:0]                         action;
  logic [i2cmbe_pkg::BYTE_W-1:0]      write_byte;
  logic                               sda_in;
  logic                               done;

  assign action     = in_tuser;
  assign write_byte = in_tdata[7:0];
  assign sda_in     = in_tdata[8];

  // Take an item when the result slot is empty or drains this cycle
  assign in_tready  = !out_valid_r || out_tready;
  assign in_accept  = in_tvalid && in_tready;

  always_comb begin
    i2cmbe_pkg::cmd_t               cmd_v;
    logic [i2cmbe_pkg::PHASE_W-1:0] ph;
    cmd_v     = cmd_r;
    ph        = phase_r;
    shift_nxt = shift_r;
    hold_nxt  = hold_r;
    ack_nxt   = ack_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drv_nxt   = drv_r;
    done      = 1'b0;

    // Latch a new command only while idle; unknown codes are plain ticks
    if (cmd_r == i2cmbe_pkg::CMD_IDLE &&
        action inside {[i2cmbe_pkg::CMD_START:i2cmbe_pkg::CMD_STOP]}) begin
      cmd_v = action;
      ph    = '0;
      if (action == i2cmbe_pkg::CMD_WRITE) begin
        shift_nxt = write_byte;
      end
    end

    case (cmd_v)
      i2cmbe_pkg::CMD_START: begin
        case (ph)
          5'd0: begin
            sda_nxt = 1'b1;
            drv_nxt = 1'b1;
          end
          5'd1: scl_nxt = 1'b1;
          5'd2: sda_nxt = 1'b0;
          default: begin
            scl_nxt = 1'b0;
            done    = 1'b1;
          end
        endcase
      end
      i2cmbe_pkg::CMD_WRITE: begin
        if (ph < i2cmbe_pkg::PH_BITS_END) begin
          if (!ph[0]) begin
            // SCL low, present the next bit MSB first
            scl_nxt = 1'b0;
            drv_nxt = 1'b1;
            sda_nxt = shift_nxt[i2cmbe_pkg::BYTE_W-1];
          end else begin
            scl_nxt   = 1'b1;
            shift_nxt = {shift_nxt[i2cmbe_pkg::BYTE_W-2:0], 1'b0};
          end
        end else if (ph == i2cmbe_pkg::PH_BITS_END) begin
          // Release SDA for the slave's ACK
          scl_nxt = 1'b0;
          drv_nxt = 1'b0;
        end else if (ph == i2cmbe_pkg::PH_ACK_HIGH) begin
          scl_nxt = 1'b1;
        end else begin
          // Sample ACK with SCL still high
          ack_nxt = !sda_in;
          scl_nxt = 1'b0;
          drv_nxt = 1'b1;
          done    = 1'b1;
        end
      end
      i2cmbe_pkg::CMD_READ: begin
        if (ph == '0) begin
          scl_nxt   = 1'b0;
          drv_nxt   = 1'b0;
          shift_nxt = '0;
        end else if (ph <= i2cmbe_pkg::PH_BITS_END) begin
          if (ph[0]) begin
            scl_nxt = 1'b1;
          end else begin
            shift_nxt = {shift_nxt[i2cmbe_pkg::BYTE_W-2:0], sda_in};
            scl_nxt   = 1'b0;
          end
        end else if (ph == i2cmbe_pkg::PH_NACK_DRV) begin
          drv_nxt = 1'b1;
          sda_nxt = 1'b1;
        end else if (ph == i2cmbe_pkg::PH_NACK_HIGH) begin
          scl_nxt = 1'b1;
        end else begin
          scl_nxt  = 1'b0;
          hold_nxt = shift_nxt;
          done     = 1'b1;
        end
      end
      i2cmbe_pkg::CMD_STOP: begin
        case (ph)
          5'd0: scl_nxt = 1'b0;
          5'd1: begin
            sda_nxt = 1'b0;
            drv_nxt = 1'b1;
          end
          5'd2: scl_nxt = 1'b1;
          default: begin
            sda_nxt = 1'b1;
            done    = 1'b1;
          end
        endcase
      end
      default: ;  // idle: hold the lines
    endcase

    // Advance the phase, or drop back to idle at the end of a command
    if (done) begin
      cmd_nxt   = i2cmbe_pkg::CMD_IDLE;
      phase_nxt = '0;
    end else if (cmd_v != i2cmbe_pkg::CMD_IDLE) begin
      cmd_nxt   = cmd_v;
      phase_nxt = ph + 5'd1;
    end else begin
      cmd_nxt   = cmd_v;
      phase_nxt = ph;
    end

    res_nxt.scl_level    = scl_nxt;
    res_nxt.sda_level    = sda_nxt;
    res_nxt.sda_drive    = drv_nxt;
    res_nxt.busy_res     = (cmd_nxt != i2cmbe_pkg::CMD_IDLE);
    res_nxt.done_res     = done;
    res_nxt.ack_received = ack_nxt;
    res_nxt.read_byte    = hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r       <= i2cmbe_pkg::CMD_IDLE;
      phase_r     <= '0;
      shift_r     <= '0;
      hold_r      <= '0;
      ack_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      drv_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        cmd_r   <= cmd_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        hold_r  <= hold_nxt;
        ack_r   <= ack_nxt;
        scl_r   <= scl_nxt;
        sda_r   <= sda_nxt;
        drv_r   <= drv_nxt;
      end
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    if (in_accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(i2cmbe_pkg::OUT_DATA_W - $bits(i2cmbe_pkg::result_t)){1'b0}}, res_r};

`ifndef SYNTHESIS
  // Idle always sits at phase zero
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == i2cmbe_pkg::CMD_IDLE |-> phase_r == '0)
    else $error("phase counter not cleared while idle");

  // No command runs past its last phase
  a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= i2cmbe_pkg::PH_LAST)
    else $error("phase counter beyond last phase");

  // A finished command reports idle in the same item
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.done_res |-> !res_r.busy_res)
    else $error("done reported while still busy");

  // Every accepted item leaves a result behind
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted item produced no result");
`endif

endmodule
